// File: sv/i2csbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C slave byte sequencer package
// Shared codes, state types and the beat structures of the sequencer.
// ----------------------------------------------------------------------------
package i2csbs_pkg;

   // Bus event codes carried in req_type.
   localparam logic [1:0] REQ_START      = 2'd0;
   localparam logic [1:0] REQ_START_STOP = 2'd1;
   localparam logic [1:0] REQ_SHIFT_DONE = 2'd2;

   // Sequencer phase.
   typedef enum logic [2:0] {
      PH_CHECK_ADDR  = 3'd0,
      PH_SEND_DATA   = 3'd1,
      PH_REQ_REPLY   = 3'd2,
      PH_CHECK_REPLY = 3'd3,
      PH_REQ_DATA    = 3'd4,
      PH_GET_DATA    = 3'd5
   } phase_type;

   // Line actions.
   localparam logic [2:0] ACT_NONE      = 3'd0;
   localparam logic [2:0] ACT_SEND_ACK  = 3'd1;
   localparam logic [2:0] ACT_SEND_DATA = 3'd2;
   localparam logic [2:0] ACT_READ_ACK  = 3'd3;
   localparam logic [2:0] ACT_READ_DATA = 3'd4;
   localparam logic [2:0] ACT_LISTEN    = 3'd5;
   localparam logic [2:0] ACT_ARMED     = 3'd6;

   // Application notifications.
   localparam logic [2:0] NOTE_NONE  = 3'd0;
   localparam logic [2:0] NOTE_START = 3'd1;
   localparam logic [2:0] NOTE_READ  = 3'd2;
   localparam logic [2:0] NOTE_WRITE = 3'd3;
   localparam logic [2:0] NOTE_STOP  = 3'd4;

   // General call address byte.
   localparam logic [7:0] GENERAL_CALL = 8'h00;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] shift_data;
      logic [7:0] tx_byte;
   } req_beat_type;

   typedef struct packed {
      logic [2:0] line_action;
      logic [2:0] notify_kind;
      logic       rw_bit;
      logic [7:0] data_out;
   } rsp_beat_type;

   typedef struct packed {
      phase_type phase;
      logic      ovf_en;
   } seq_state_type;

endpackage

// File: sv/i2csbs_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one bus event beat into the sequencer.
// ----------------------------------------------------------------------------
interface i2csbs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] shift_data;
   logic [7:0] tx_byte;

   modport source (output valid, output req_type, output shift_data, output tx_byte,
                   input ready);
   modport sink (input valid, input req_type, input shift_data, input tx_byte,
                 output ready);
endinterface

// File: sv/i2csbs_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result beat out of the sequencer.
// ----------------------------------------------------------------------------
interface i2csbs_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] line_action;
   logic [2:0] notify_kind;
   logic       rw_bit;
   logic [7:0] data_out;

   modport source (output valid, output line_action, output notify_kind,
                   output rw_bit, output data_out, input ready);
   modport sink (input valid, input line_action, input notify_kind,
                 input rw_bit, input data_out, output ready);
endinterface

// File: sv/i2csbs_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C slave sequencer step
// Decodes one bus event against the current phase and gives the result beat
// and the next sequencer state.
// ----------------------------------------------------------------------------
module i2csbs_step
   import i2csbs_pkg::*;
(
   input  req_beat_type  req_beat,
   input  seq_state_type cur_state,
   input  logic [6:0]    own_address,
   output rsp_beat_type  rsp_beat,
   output seq_state_type nxt_state
);

   logic addr_hit;

   // The address byte matches our address or is a general call.
   assign addr_hit = (req_beat.shift_data == GENERAL_CALL) ||
                     (req_beat.shift_data[7:1] == own_address);

   always_comb begin
      rsp_beat  = '0;
      nxt_state = cur_state;
      unique case (req_beat.req_type)
         REQ_START: begin
            nxt_state.phase  = PH_CHECK_ADDR;
            nxt_state.ovf_en = 1'b1;
            rsp_beat.line_action = ACT_ARMED;
         end
         REQ_START_STOP: begin
            nxt_state.phase  = PH_CHECK_ADDR;
            nxt_state.ovf_en = 1'b0;
            rsp_beat.notify_kind = NOTE_STOP;
            rsp_beat.line_action = ACT_LISTEN;
         end
         REQ_SHIFT_DONE: begin
            if (cur_state.ovf_en) begin
               unique case (cur_state.phase)
                  PH_CHECK_ADDR: begin
                     if (addr_hit) begin
                        rsp_beat.rw_bit      = req_beat.shift_data[0];
                        rsp_beat.notify_kind = NOTE_START;
                        rsp_beat.line_action = ACT_SEND_ACK;
                        nxt_state.phase = req_beat.shift_data[0] ? PH_SEND_DATA
                                                                 : PH_REQ_DATA;
                     end else begin
                        nxt_state.ovf_en     = 1'b0;
                        rsp_beat.line_action = ACT_LISTEN;
                     end
                  end
                  PH_CHECK_REPLY: begin
                     // Any nonzero sample is a NACK from the master.
                     if (req_beat.shift_data != 8'd0) begin
                        nxt_state.ovf_en     = 1'b0;
                        rsp_beat.line_action = ACT_LISTEN;
                     end else begin
                        rsp_beat.data_out    = req_beat.tx_byte;
                        rsp_beat.notify_kind = NOTE_READ;
                        rsp_beat.line_action = ACT_SEND_DATA;
                        nxt_state.phase      = PH_REQ_REPLY;
                     end
                  end
                  PH_SEND_DATA: begin
                     rsp_beat.data_out    = req_beat.tx_byte;
                     rsp_beat.notify_kind = NOTE_READ;
                     rsp_beat.line_action = ACT_SEND_DATA;
                     nxt_state.phase      = PH_REQ_REPLY;
                  end
                  PH_REQ_REPLY: begin
                     nxt_state.phase      = PH_CHECK_REPLY;
                     rsp_beat.line_action = ACT_READ_ACK;
                  end
                  PH_REQ_DATA: begin
                     nxt_state.phase      = PH_GET_DATA;
                     rsp_beat.line_action = ACT_READ_DATA;
                  end
                  PH_GET_DATA: begin
                     rsp_beat.notify_kind = NOTE_WRITE;
                     rsp_beat.data_out    = req_beat.shift_data;
                     rsp_beat.line_action = ACT_SEND_ACK;
                     nxt_state.phase      = PH_REQ_DATA;
                  end
                  default: begin
                     rsp_beat  = '0;
                     nxt_state = cur_state;
                  end
               endcase
            end
         end
         default: begin
            rsp_beat  = '0;
            nxt_state = cur_state;
         end
      endcase
   end

endmodule

// File: sv/i2c_slave_byte_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C slave byte sequencer
// Byte-level sequencer of a seven-bit-address I2C slave: one result per event.
// ----------------------------------------------------------------------------
// Every accepted request beat yields exactly one response beat when the
// response side is ready. Unless stalled, a new event is taken every cycle:
// the event is captured in an input register, decoded by one small step of
// logic against the phase register, and written to an output register backed
// by a one-entry skid stage, so a stalled response does not stop the request
// side until both output entries are full. The own address is written through
// csr_wr_en/csr_wr_data and should only change while no beat is in flight.
// ----------------------------------------------------------------------------
module i2c_slave_byte_sequencer
   import i2csbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data,
   i2csbs_req_if.sink  req_chan,
   i2csbs_rsp_if.source rsp_chan
);

   logic [6:0]    own_addr_ff;
   logic          s1_valid_ff;
   req_beat_type  s1_beat_ff;
   seq_state_type state_ff;
   seq_state_type state_in;
   rsp_beat_type  step_rsp;
   logic          main_valid_ff;
   logic          main_valid_in;
   rsp_beat_type  main_beat_ff;
   rsp_beat_type  main_beat_in;
   logic          skid_valid_ff;
   logic          skid_valid_in;
   rsp_beat_type  skid_beat_ff;
   rsp_beat_type  skid_beat_in;
   logic          req_take;
   logic          s1_move;
   logic          rsp_pop;

   // Own address register.
   always_ff @(posedge clock) begin
      if (reset) begin
         own_addr_ff <= 7'd0;
      end else if (csr_wr_en) begin
         own_addr_ff <= csr_wr_data;
      end
   end

   // Handshakes: the input stage drains whenever the skid stage is free.
   assign s1_move  = s1_valid_ff && !skid_valid_ff;
   assign req_chan.ready = !s1_valid_ff || !skid_valid_ff;
   assign req_take = req_chan.valid && req_chan.ready;
   assign rsp_pop  = main_valid_ff && rsp_chan.ready;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_beat_ff.req_type   <= req_chan.req_type;
         s1_beat_ff.shift_data <= req_chan.shift_data;
         s1_beat_ff.tx_byte    <= req_chan.tx_byte;
      end
   end

   // Event decode.
   i2csbs_step u_step (
      .req_beat    (s1_beat_ff),
      .cur_state   (state_ff),
      .own_address (own_addr_ff),
      .rsp_beat    (step_rsp),
      .nxt_state   (state_in)
   );

   // Sequencer state advances as each beat leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase  <= PH_CHECK_ADDR;
         state_ff.ovf_en <= 1'b0;
      end else if (s1_move) begin
         state_ff <= state_in;
      end
   end

   // Output register and skid stage, kept in order.
   always_comb begin
      main_valid_in = main_valid_ff;
      main_beat_in  = main_beat_ff;
      skid_valid_in = skid_valid_ff;
      skid_beat_in  = skid_beat_ff;
      if (rsp_pop) begin
         if (skid_valid_ff) begin
            main_beat_in  = skid_beat_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = s1_move;
            main_beat_in  = step_rsp;
         end
      end else if (s1_move) begin
         if (main_valid_ff) begin
            skid_valid_in = 1'b1;
            skid_beat_in  = step_rsp;
         end else begin
            main_valid_in = 1'b1;
            main_beat_in  = step_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_beat_ff <= main_beat_in;
      skid_beat_ff <= skid_beat_in;
   end

   // Response port.
   assign rsp_chan.valid       = main_valid_ff;
   assign rsp_chan.line_action = main_beat_ff.line_action;
   assign rsp_chan.notify_kind = main_beat_ff.notify_kind;
   assign rsp_chan.rw_bit      = main_beat_ff.rw_bit;
   assign rsp_chan.data_out    = main_beat_ff.data_out;

`ifndef SYNTH
   // The skid stage only holds a beat behind a held output beat.
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid stage valid without output beat");

   // Popping with a beat in the skid stage keeps the output valid.
   a_skid_refill: assert property (@(posedge clock) disable iff (reset)
      (main_valid_ff && skid_valid_ff && rsp_chan.ready) |=> main_valid_ff)
      else $error("skid beat lost on pop");

   // A start event always arms overflow handling.
   a_start_arms: assert property (@(posedge clock) disable iff (reset)
      (s1_move && s1_beat_ff.req_type == REQ_START) |=> state_ff.ovf_en)
      else $error("start did not arm overflow handling");

   // A start-then-stop event always disarms and returns to address check.
   a_stop_disarms: assert property (@(posedge clock) disable iff (reset)
      (s1_move && s1_beat_ff.req_type == REQ_START_STOP) |=>
      (!state_ff.ovf_en && state_ff.phase == PH_CHECK_ADDR))
      else $error("stop did not return to listen");
`endif

endmodule

// File: test/i2c_slave_byte_sequencer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C slave byte sequencer checker
// Watches the request, response and register ports of the sequencer. It keeps
// its own copy of the phase, the overflow enable and the slave address. From
// these it works out the response to every accepted request beat, and it
// compares each response beat field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module i2c_slave_byte_sequencer_checker
   import i2csbs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [6:0] csr_wr_data,
   i2csbs_req_if      req_chan,
   i2csbs_rsp_if      rsp_chan,
   output int         mismatches,
   output int         in_flight,
   output int         responses_checked,
   output int         bytes_received,
   output int         bytes_sent
);

   // Shadow copy of the sequencer state and its address register.
   logic [6:0]   slave_addr;
   phase_type    seq_phase;
   logic         ovf_armed;

   // Responses that are due, oldest first.
   rsp_beat_type due_responses[$];

   int           error_total;
   int           checked_total;
   int           rx_total;
   int           tx_total;
   rsp_beat_type got_beat;
   rsp_beat_type want_beat;
   req_beat_type event_beat;

   // Advance the shadow state by one bus event and return the response it
   // should produce.
   function automatic rsp_beat_type decode_bus_event(input req_beat_type ev);
      rsp_beat_type res;
      res = '0;
      case (ev.req_type)
         REQ_START: begin
            seq_phase = PH_CHECK_ADDR;
            ovf_armed = 1'b1;
            res.line_action = ACT_ARMED;
         end
         REQ_START_STOP: begin
            seq_phase = PH_CHECK_ADDR;
            ovf_armed = 1'b0;
            res.notify_kind = NOTE_STOP;
            res.line_action = ACT_LISTEN;
         end
         REQ_SHIFT_DONE: begin
            // Overflow events are dropped while only start detection is on.
            if (ovf_armed) begin
               case (seq_phase)
                  PH_CHECK_ADDR: begin
                     if (ev.shift_data == GENERAL_CALL ||
                         ev.shift_data[7:1] == slave_addr) begin
                        res.rw_bit      = ev.shift_data[0];
                        res.notify_kind = NOTE_START;
                        res.line_action = ACT_SEND_ACK;
                        if (ev.shift_data[0]) begin
                           seq_phase = PH_SEND_DATA;
                        end else begin
                           seq_phase = PH_REQ_DATA;
                        end
                     end else begin
                        ovf_armed = 1'b0;
                        res.line_action = ACT_LISTEN;
                     end
                  end
                  PH_SEND_DATA, PH_CHECK_REPLY: begin
                     // A nonzero reply sample is a NACK from the master.
                     if (seq_phase == PH_CHECK_REPLY && ev.shift_data != 8'h00) begin
                        ovf_armed = 1'b0;
                        res.line_action = ACT_LISTEN;
                     end else begin
                        res.data_out    = ev.tx_byte;
                        res.notify_kind = NOTE_READ;
                        res.line_action = ACT_SEND_DATA;
                        seq_phase = PH_REQ_REPLY;
                     end
                  end
                  PH_REQ_REPLY: begin
                     seq_phase = PH_CHECK_REPLY;
                     res.line_action = ACT_READ_ACK;
                  end
                  PH_REQ_DATA: begin
                     seq_phase = PH_GET_DATA;
                     res.line_action = ACT_READ_DATA;
                  end
                  PH_GET_DATA: begin
                     res.notify_kind = NOTE_WRITE;
                     res.data_out    = ev.shift_data;
                     res.line_action = ACT_SEND_ACK;
                     seq_phase = PH_REQ_DATA;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // Compare one response beat with its expectation; returns the number of
   // wrong fields.
   function automatic int count_field_errors(input rsp_beat_type want,
                                             input rsp_beat_type got);
      int bad;
      bad = 0;
      if (got.line_action !== want.line_action) begin
         $error("line_action: expected %0d, got %0d", want.line_action, got.line_action);
         bad++;
      end
      if (got.notify_kind !== want.notify_kind) begin
         $error("notify_kind: expected %0d, got %0d", want.notify_kind, got.notify_kind);
         bad++;
      end
      if (got.rw_bit !== want.rw_bit) begin
         $error("rw_bit: expected %0d, got %0d", want.rw_bit, got.rw_bit);
         bad++;
      end
      if (got.data_out !== want.data_out) begin
         $error("data_out: expected 0x%02h, got 0x%02h", want.data_out, got.data_out);
         bad++;
      end
      return bad;
   endfunction

   // Sample all ports at the rising edge; outputs are published once per edge.
   always @(posedge clock) begin
      if (reset) begin
         due_responses.delete();
         slave_addr = '0;
         seq_phase  = PH_CHECK_ADDR;
         ovf_armed  = 1'b0;
      end else begin
         // Response side first: a beat taken now can never be for a request
         // taken at the same edge.
         if (rsp_chan.valid && rsp_chan.ready) begin
            got_beat.line_action = rsp_chan.line_action;
            got_beat.notify_kind = rsp_chan.notify_kind;
            got_beat.rw_bit      = rsp_chan.rw_bit;
            got_beat.data_out    = rsp_chan.data_out;
            if (due_responses.size() == 0) begin
               $error("response beat with none due: line_action %0d, notify_kind %0d",
                      got_beat.line_action, got_beat.notify_kind);
               error_total++;
            end else begin
               want_beat = due_responses.pop_front();
               error_total += count_field_errors(want_beat, got_beat);
               checked_total++;
               if (want_beat.notify_kind == NOTE_WRITE) rx_total++;
               if (want_beat.notify_kind == NOTE_READ) tx_total++;
            end
         end

         if (csr_wr_en) slave_addr = csr_wr_data;

         if (req_chan.valid && req_chan.ready) begin
            event_beat.req_type   = req_chan.req_type;
            event_beat.shift_data = req_chan.shift_data;
            event_beat.tx_byte    = req_chan.tx_byte;
            due_responses.push_back(decode_bus_event(event_beat));
         end
      end

      mismatches        <= error_total;
      in_flight         <= due_responses.size();
      responses_checked <= checked_total;
      bytes_received    <= rx_total;
      bytes_sent        <= tx_total;
   end

endmodule

// File: test/i2c_slave_byte_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C slave byte sequencer testbench
// Drives bus events into the sequencer: a short directed pass over the special
// cases, then random master read and write transfers with noise, under
// several slave addresses. Both handshake sides idle at random. The checker
// beside the block judges every response beat.
// ----------------------------------------------------------------------------
module i2c_slave_byte_sequencer_tb;
   import i2csbs_pkg::*;

   localparam int RESET_CYCLES = 9;
   localparam int DRAIN_CYCLES = 4;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int PHASE_EVENTS = 240;

   typedef enum int {
      ALWAYS_READY,
      COIN_FLIP,
      MOSTLY_READY,
      EVERY_FOURTH_LOW
   } stall_mode_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_wr_en;
   logic [6:0] csr_wr_data;

   i2csbs_req_if req_chan ();
   i2csbs_rsp_if rsp_chan ();

   int mismatches;
   int in_flight;
   int responses_checked;
   int bytes_received;
   int bytes_sent;

   int             events_sent;
   int             burst_left;
   int             gapless_left;
   int             holds_wanted;
   int             holds_granted;
   int             addr_settings;
   int             cycle_count;
   bit             steady_sender;
   logic [6:0]     own_now;
   logic [6:0]     addr_plan [8];
   stall_mode_type stall_mode;

   always #5 clock = ~clock;

   i2c_slave_byte_sequencer dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   i2c_slave_byte_sequencer_checker seq_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_chan          (req_chan),
      .rsp_chan          (rsp_chan),
      .mismatches        (mismatches),
      .in_flight         (in_flight),
      .responses_checked (responses_checked),
      .bytes_received    (bytes_received),
      .bytes_sent        (bytes_sent)
   );

   function automatic logic [7:0] rand_byte();
      return 8'($urandom);
   endfunction

   // Data bytes lean toward the all-zero and all-one extremes.
   function automatic logic [7:0] data_byte();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 8'h00;
      if (pick == 1) return 8'hFF;
      return 8'($urandom);
   endfunction

   // Mostly the own address, sometimes a general call or any byte at all.
   function automatic logic [7:0] pick_address(input logic rw);
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 14) return {own_now, rw};
      if (pick < 17) return GENERAL_CALL;
      return 8'($urandom);
   endfunction

   // Offer one event beat and hold it until it is taken. Between bursts the
   // valid line drops for a random gap unless the sender runs steady.
   task automatic send_event(input logic [1:0] kind, input logic [7:0] sd,
                             input logic [7:0] tx);
      int gap;
      if (gapless_left > 0) begin
         gapless_left--;
      end else if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = steady_sender ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_chan.valid      <= 1'b1;
      req_chan.req_type   <= kind;
      req_chan.shift_data <= sd;
      req_chan.tx_byte    <= tx;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      events_sent++;
   endtask

   // Stop offering and wait until every due response has come back.
   task automatic drain_sequencer();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (in_flight != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_own_address(input logic [6:0] addr);
      drain_sequencer();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= addr;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      own_now = addr;
      addr_settings++;
   endtask

   // Random bus traffic: mostly well-formed transfers with random content,
   // the rest broken transfers and plain noise.
   task automatic run_bus_traffic(input int count);
      int stop_at;
      int pick;
      int n;
      stop_at = events_sent + count;
      while (events_sent < stop_at) begin
         pick = $urandom_range(0, 99);
         n = $urandom_range(0, 6);
         if (pick < 40) begin
            // Master writes: address, then pairs of ACK slot and data byte.
            send_event(REQ_START, rand_byte(), rand_byte());
            send_event(REQ_SHIFT_DONE, pick_address(1'b0), rand_byte());
            repeat (n) begin
               send_event(REQ_SHIFT_DONE, rand_byte(), rand_byte());
               send_event(REQ_SHIFT_DONE, data_byte(), rand_byte());
            end
            if ($urandom_range(0, 4) != 0)
               send_event(REQ_START_STOP, rand_byte(), rand_byte());
         end else if (pick < 75) begin
            // Master reads: each acknowledged byte loads the next, a NACK ends.
            send_event(REQ_START, rand_byte(), rand_byte());
            send_event(REQ_SHIFT_DONE, pick_address(1'b1), rand_byte());
            send_event(REQ_SHIFT_DONE, rand_byte(), data_byte());
            repeat (n) begin
               send_event(REQ_SHIFT_DONE, rand_byte(), rand_byte());
               send_event(REQ_SHIFT_DONE, 8'h00, data_byte());
            end
            send_event(REQ_SHIFT_DONE, rand_byte(), rand_byte());
            send_event(REQ_SHIFT_DONE, 8'($urandom_range(1, 255)), data_byte());
            if ($urandom_range(0, 4) != 0)
               send_event(REQ_START_STOP, rand_byte(), rand_byte());
         end else if (pick < 88) begin
            // Broken transfer: start, then overflows with arbitrary contents.
            send_event(REQ_START, rand_byte(), rand_byte());
            repeat (n) send_event(REQ_SHIFT_DONE, data_byte(), data_byte());
         end else begin
            // Noise, including the unused event code.
            repeat (n + 1)
               send_event(2'($urandom_range(0, 3)), data_byte(), data_byte());
         end
      end
   endtask

   // Response side: changing stall patterns, with a long hold-off on request.
   initial begin
      int mode_left;
      mode_left = 0;
      stall_mode = ALWAYS_READY;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (holds_wanted > holds_granted) begin
            holds_granted++;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               stall_mode = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (stall_mode)
               ALWAYS_READY: rsp_chan.ready <= 1'b1;
               COIN_FLIP:    rsp_chan.ready <= 1'($urandom_range(0, 1));
               MOSTLY_READY: rsp_chan.ready <= ($urandom_range(0, 7) != 0);
               default:      rsp_chan.ready <= ((mode_left % 4) != 0);
            endcase
         end
         @(posedge clock);
      end
   end

   // Watchdog on the whole run.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run did not finish within %0d cycles.", CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Stimulus and verdict.
   initial begin
      events_sent   = 0;
      burst_left    = 0;
      gapless_left  = 0;
      holds_wanted  = 0;
      holds_granted = 0;
      addr_settings = 0;
      steady_sender = 1'b0;
      own_now       = 7'h00;
      addr_plan     = '{7'h00, 7'h7F, 7'h01, 7'h2A, 7'h40, 7'h00, 7'h55, 7'h7F};
      addr_plan[3]  = 7'($urandom);
      addr_plan[6]  = 7'($urandom);

      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= 7'h00;
      req_chan.valid      <= 1'b0;
      req_chan.req_type   <= REQ_START;
      req_chan.shift_data <= 8'h00;
      req_chan.tx_byte    <= 8'h00;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Address still at its reset value of zero: overflow while disabled,
      // unused event code, then a read addressed as 0x01 ending in a NACK.
      send_event(REQ_SHIFT_DONE, 8'hFF, 8'hFF);
      send_event(2'd3, 8'hFF, 8'hFF);
      send_event(REQ_START, 8'h00, 8'h00);
      send_event(REQ_SHIFT_DONE, 8'h01, 8'h00);
      send_event(REQ_SHIFT_DONE, 8'h00, 8'hFF);
      send_event(REQ_SHIFT_DONE, 8'hFF, 8'h00);
      send_event(REQ_SHIFT_DONE, 8'h00, 8'h00);
      send_event(REQ_SHIFT_DONE, 8'h00, 8'hFF);
      send_event(REQ_SHIFT_DONE, 8'hFF, 8'hFF);
      send_event(REQ_SHIFT_DONE, 8'h00, 8'hFF);
      send_event(REQ_START_STOP, 8'hFF, 8'hFF);

      // Top address: write transfer, repeated start with a general call,
      // address mismatch, then a read that the master NACKs.
      write_own_address(7'h7F);
      send_event(REQ_START, 8'hFF, 8'hFF);
      send_event(REQ_SHIFT_DONE, 8'hFE, 8'h00);
      send_event(REQ_SHIFT_DONE, 8'h00, 8'h00);
      send_event(REQ_SHIFT_DONE, 8'hFF, 8'h00);
      send_event(REQ_SHIFT_DONE, 8'hFF, 8'hFF);
      send_event(REQ_SHIFT_DONE, 8'h00, 8'hFF);
      send_event(REQ_START, 8'h00, 8'h00);
      send_event(REQ_SHIFT_DONE, GENERAL_CALL, 8'hFF);
      send_event(REQ_START, 8'h00, 8'h00);
      send_event(REQ_SHIFT_DONE, 8'h02, 8'h00);
      send_event(REQ_START, 8'h00, 8'h00);
      send_event(REQ_SHIFT_DONE, 8'hFF, 8'h00);
      send_event(REQ_SHIFT_DONE, 8'h00, 8'hA5);
      send_event(REQ_SHIFT_DONE, 8'h00, 8'h00);
      send_event(REQ_SHIFT_DONE, 8'h80, 8'h00);
      send_event(REQ_START_STOP, 8'h00, 8'h00);

      // Random phases, one slave address each. One phase runs the sender
      // without gaps into a long response hold-off.
      for (int p = 0; p < 8; p++) begin
         write_own_address(addr_plan[p]);
         steady_sender = (p == 1 || p == 5);
         if (p == 2) begin
            holds_wanted++;
            gapless_left = 40;
         end
         run_bus_traffic(PHASE_EVENTS);
      end

      drain_sequencer();
      $display("Drove %0d bus events under %0d address settings; %0d responses checked.",
               events_sent, addr_settings + 1, responses_checked);
      $display("The slave took %0d bytes from masters and loaded %0d bytes for them.",
               bytes_received, bytes_sent);
      if (mismatches == 0 && in_flight == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/i2csbs_pkg.sv
sv/i2csbs_req_if.sv
sv/i2csbs_rsp_if.sv
sv/i2csbs_step.sv
sv/i2c_slave_byte_sequencer.sv
test/i2c_slave_byte_sequencer_checker.sv
test/i2c_slave_byte_sequencer_tb.sv
